/* rtl/scc_pkg.sv */
// Shared types, constants and helper functions for the SCC search block.
`default_nettype none
package scc_pkg;

	// Graph size and derived widths
	localparam int MAX_V = 64;
	localparam int VW    = $clog2(MAX_V);
	localparam int CW    = VW + 1;
	localparam int FRW   = VW + CW;

	// Input command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_FIND  = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_ADD_WR, ST_ROOT, ST_ENTER, ST_ROW_RD, ST_ROW,
		ST_PICK, ST_CHECK, ST_LOW_MIN, ST_DONE, ST_POP_RD, ST_POP, ST_EMIT,
		ST_RET, ST_RET1, ST_RET2, ST_FINISH
	} state_t;

	// Datapath commands
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_CLEAR, OP_ADD_RD, OP_ADD_WR, OP_INIT, OP_ROOT_NEXT,
		OP_ROOT_TAKE, OP_ENTER, OP_ROW_RD, OP_ROW, OP_PICK, OP_SAVE, OP_LOW_RD,
		OP_LOW_MIN, OP_DONE, OP_POP_RD, OP_POP, OP_EMIT, OP_COMP_NEXT,
		OP_RET_ROOT, OP_RET, OP_RET1, OP_RET2, OP_FINISH
	} dp_op_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic is_clear;
		logic is_add;
		logic is_find;
		logic add_ok;
		logic root_done;
		logic root_visited;
		logic succ_empty;
		logic w_visited;
		logic w_on_stack;
		logic is_comp_root;
		logic u_is_v;
		logic members_empty;
		logic depth_one;
	} dp_status_t;

	// Mask of the bits below n
	function automatic logic [MAX_V-1:0] low_mask(input logic [CW-1:0] n);
		logic [MAX_V-1:0] m;
		for (int i = 0; i < MAX_V; i++) begin
			m[i] = (CW'(i) < n);
		end
		return m;
	endfunction

	// Index of the lowest set bit
	function automatic logic [VW-1:0] first_one(input logic [MAX_V-1:0] x);
		logic [VW-1:0] r;
		r = '0;
		for (int i = MAX_V - 1; i >= 0; i--) begin
			if (x[i]) r = VW'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/scc_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/scc_ctrl.sv */
// Controller state machine sequencing graph loading and the Tarjan search.
`default_nettype none
module scc_ctrl
	import scc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire dp_status_t st,
	output dp_op_t          op
);
	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op      = OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (st.is_clear) begin
					op = OP_CLEAR;
				end else if (st.is_add && st.add_ok) begin
					op      = OP_ADD_RD;
					state_d = ST_ADD_WR;
				end else if (st.is_find) begin
					op      = OP_INIT;
					state_d = ST_ROOT;
				end
			end
			ST_ADD_WR: begin
				op      = OP_ADD_WR;
				state_d = ST_IDLE;
			end
			ST_ROOT: begin
				if (st.root_done) begin
					state_d = ST_FINISH;
				end else if (st.root_visited) begin
					op = OP_ROOT_NEXT;
				end else begin
					op      = OP_ROOT_TAKE;
					state_d = ST_ENTER;
				end
			end
			ST_ENTER: begin
				op      = OP_ENTER;
				state_d = ST_ROW_RD;
			end
			ST_ROW_RD: begin
				op      = OP_ROW_RD;
				state_d = ST_ROW;
			end
			ST_ROW: begin
				op      = OP_ROW;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (st.succ_empty) begin
					state_d = ST_DONE;
				end else begin
					op      = OP_PICK;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!st.w_visited) begin
					op      = OP_SAVE;
					state_d = ST_ENTER;
				end else if (st.w_on_stack) begin
					op      = OP_LOW_RD;
					state_d = ST_LOW_MIN;
				end else begin
					state_d = ST_PICK;
				end
			end
			ST_LOW_MIN: begin
				op      = OP_LOW_MIN;
				state_d = ST_PICK;
			end
			ST_DONE: begin
				op      = OP_DONE;
				state_d = st.is_comp_root ? ST_POP_RD : ST_RET;
			end
			ST_POP_RD: begin
				op      = OP_POP_RD;
				state_d = ST_POP;
			end
			ST_POP: begin
				op      = OP_POP;
				state_d = st.u_is_v ? ST_EMIT : ST_POP_RD;
			end
			ST_EMIT: begin
				if (st.members_empty) begin
					op      = OP_COMP_NEXT;
					state_d = ST_RET;
				end else begin
					op = OP_EMIT;
				end
			end
			ST_RET: begin
				if (st.depth_one) begin
					op      = OP_RET_ROOT;
					state_d = ST_ROOT;
				end else begin
					op      = OP_RET;
					state_d = ST_RET1;
				end
			end
			ST_RET1: begin
				op      = OP_RET1;
				state_d = ST_RET2;
			end
			ST_RET2: begin
				op      = OP_RET2;
				state_d = ST_ROW_RD;
			end
			ST_FINISH: begin
				op      = OP_FINISH;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/scc_dp.sv */
// Datapath: adjacency memory, search memories, masks, counters and result registers.
`default_nettype none
module scc_dp
	import scc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dp_op_t        op,
	output dp_status_t         st,
	input  wire logic [1:0]    cmd,
	input  wire logic [VW-1:0] from_vertex,
	input  wire logic [VW-1:0] to_vertex,
	input  wire logic          cfg_we,
	input  wire logic [CW-1:0] cfg_wdata,
	output logic               result_strobe,
	output logic [VW-1:0]      member_vertex,
	output logic [VW-1:0]      component_number,
	output logic               component_end,
	output logic               run_end
);
	// Registers
	logic [CW-1:0]    vcount_q;
	logic [1:0]       cmd_q;
	logic [VW-1:0]    from_q, to_q;
	logic [MAX_V-1:0] row_valid_q;
	logic [CW-1:0]    n_q, root_q, sp_q, dp_q, order_q, comp_q;
	logic [MAX_V-1:0] visited_q, on_stack_q, succ_q, members_q;
	logic [VW-1:0]    v_q, w_q, lowv_q, ordv_q;
	logic [CW-1:0]    pos_q;
	logic             pend_valid_q, pend_end_q;
	logic [VW-1:0]    pend_vertex_q, pend_comp_q;
	logic             strobe_q, comp_end_q, run_end_q;
	logic [VW-1:0]    out_vertex_q, out_comp_q;

	// Memory ports
	logic             adj_we, ord_we, low_we, stk_we, fr_we;
	logic [VW-1:0]    adj_waddr, adj_raddr, ord_raddr, low_waddr, low_raddr;
	logic [VW-1:0]    stk_raddr, fr_waddr, fr_raddr, low_wdata;
	logic [MAX_V-1:0] adj_wdata, adj_rdata;
	logic [VW-1:0]    ord_rdata, low_rdata, stk_rdata;
	logic [FRW-1:0]   fr_wdata, fr_rdata;

	logic [CW-1:0]    n_live;
	logic [VW-1:0]    first_succ, first_mem;
	logic [MAX_V-1:0] row_word;

	// Effective vertex count
	assign n_live     = (vcount_q > CW'(MAX_V)) ? CW'(MAX_V) : vcount_q;
	assign first_succ = first_one(succ_q);
	assign first_mem  = first_one(members_q);
	assign row_word   = row_valid_q[v_q] ? adj_rdata : '0;

	// Memory address and write control
	always_comb begin
		adj_we    = (op == OP_ADD_WR);
		adj_waddr = from_q;
		adj_wdata = (row_valid_q[from_q] ? adj_rdata : '0) | (MAX_V'(1) << to_q);
		adj_raddr = (op == OP_ROW_RD) ? v_q : from_q;
		ord_we    = (op == OP_ENTER);
		ord_raddr = fr_rdata[VW-1:0];
		low_we    = (op == OP_ENTER) || (op == OP_SAVE) || (op == OP_DONE);
		low_waddr = (op == OP_ENTER) ? w_q : v_q;
		low_wdata = (op == OP_ENTER) ? order_q[VW-1:0] : lowv_q;
		low_raddr = (op == OP_LOW_RD) ? w_q : fr_rdata[VW-1:0];
		stk_we    = (op == OP_ENTER);
		stk_raddr = VW'(sp_q - CW'(1));
		fr_we     = (op == OP_ENTER) || (op == OP_SAVE);
		fr_waddr  = (op == OP_ENTER) ? dp_q[VW-1:0] : VW'(dp_q - CW'(1));
		fr_wdata  = (op == OP_ENTER) ? {CW'(0), w_q} : {pos_q, v_q};
		fr_raddr  = VW'(dp_q - CW'(2));
	end

	scc_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj (
		.clk, .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);
	scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_ord (
		.clk, .we(ord_we), .waddr(w_q), .wdata(order_q[VW-1:0]),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);
	scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_low (
		.clk, .we(low_we), .waddr(low_waddr), .wdata(low_wdata),
		.raddr(low_raddr), .rdata(low_rdata)
	);
	scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_stk (
		.clk, .we(stk_we), .waddr(sp_q[VW-1:0]), .wdata(w_q),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);
	scc_ram #(.WIDTH(FRW), .DEPTH(MAX_V)) u_frame (
		.clk, .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	// Status to the controller
	always_comb begin
		st.is_clear      = (cmd_q == CMD_CLEAR);
		st.is_add        = (cmd_q == CMD_ADD);
		st.is_find       = (cmd_q == CMD_FIND);
		st.add_ok        = ({1'b0, from_q} < n_live) && ({1'b0, to_q} < n_live);
		st.root_done     = (root_q >= n_q);
		st.root_visited  = visited_q[root_q[VW-1:0]];
		st.succ_empty    = (succ_q == '0);
		st.w_visited     = visited_q[w_q];
		st.w_on_stack    = on_stack_q[w_q];
		st.is_comp_root  = (lowv_q == ordv_q);
		st.u_is_v        = (stk_rdata == v_q);
		st.members_empty = (members_q == '0);
		st.depth_one     = (dp_q == CW'(1));
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= CW'(MAX_V);
			row_valid_q  <= '0;
			visited_q    <= '0;
			on_stack_q   <= '0;
			sp_q         <= '0;
			dp_q         <= '0;
			order_q      <= '0;
			comp_q       <= '0;
			root_q       <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) vcount_q <= cfg_wdata;
			unique case (op)
				OP_CLEAR:     row_valid_q <= '0;
				OP_ADD_WR:    row_valid_q[from_q] <= 1'b1;
				OP_INIT: begin
					n_q          <= n_live;
					visited_q    <= '0;
					on_stack_q   <= '0;
					sp_q         <= '0;
					dp_q         <= '0;
					order_q      <= '0;
					comp_q       <= '0;
					root_q       <= '0;
					pend_valid_q <= 1'b0;
				end
				OP_ROOT_NEXT: root_q <= root_q + CW'(1);
				OP_RET_ROOT: begin
					root_q <= root_q + CW'(1);
					dp_q   <= '0;
				end
				OP_ENTER: begin
					sp_q            <= sp_q + CW'(1);
					dp_q            <= dp_q + CW'(1);
					order_q         <= order_q + CW'(1);
					visited_q[w_q]  <= 1'b1;
					on_stack_q[w_q] <= 1'b1;
				end
				OP_POP_RD:    sp_q <= sp_q - CW'(1);
				OP_POP:       on_stack_q[stk_rdata] <= 1'b0;
				OP_EMIT: begin
					pend_valid_q <= 1'b1;
					strobe_q     <= pend_valid_q;
				end
				OP_COMP_NEXT: comp_q <= comp_q + CW'(1);
				OP_RET:       dp_q <= dp_q - CW'(1);
				OP_FINISH: begin
					pend_valid_q <= 1'b0;
					strobe_q     <= pend_valid_q;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				cmd_q  <= cmd;
				from_q <= from_vertex;
				to_q   <= to_vertex;
			end
			OP_ROOT_TAKE: w_q <= root_q[VW-1:0];
			OP_ENTER: begin
				v_q    <= w_q;
				pos_q  <= '0;
				lowv_q <= order_q[VW-1:0];
				ordv_q <= order_q[VW-1:0];
			end
			OP_ROW:     succ_q <= row_word & low_mask(n_q) & ~low_mask(pos_q);
			OP_PICK: begin
				w_q                <= first_succ;
				pos_q              <= CW'(first_succ) + CW'(1);
				succ_q[first_succ] <= 1'b0;
			end
			OP_LOW_MIN: if (low_rdata < lowv_q) lowv_q <= low_rdata;
			OP_DONE:    members_q <= '0;
			OP_POP:     members_q[stk_rdata] <= 1'b1;
			OP_EMIT: begin
				members_q[first_mem] <= 1'b0;
				pend_vertex_q        <= first_mem;
				pend_comp_q          <= comp_q[VW-1:0];
				pend_end_q           <= ((members_q & ~(MAX_V'(1) << first_mem)) == '0);
				out_vertex_q         <= pend_vertex_q;
				out_comp_q           <= pend_comp_q;
				comp_end_q           <= pend_end_q;
				run_end_q            <= 1'b0;
			end
			OP_RET1: begin
				v_q   <= fr_rdata[VW-1:0];
				pos_q <= fr_rdata[FRW-1:VW];
			end
			OP_RET2: begin
				if (low_rdata < lowv_q) lowv_q <= low_rdata;
				ordv_q <= ord_rdata;
			end
			OP_FINISH: begin
				out_vertex_q <= pend_vertex_q;
				out_comp_q   <= pend_comp_q;
				comp_end_q   <= pend_end_q;
				run_end_q    <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result_strobe    = strobe_q;
	assign member_vertex    = out_vertex_q;
	assign component_number = out_comp_q;
	assign component_end    = comp_end_q;
	assign run_end          = run_end_q;

	// Checks; while a component is popped the call depth still counts its root
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_V)) else $error("vertex stack overflow");
	a_depth_le_sp: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q <= sp_q + CW'(1)) else $error("call depth above vertex stack");
	a_run_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && run_end_q) |=> !strobe_q) else $error("result after run end");
	a_last_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && run_end_q) |-> comp_end_q) else $error("run end mid component");
endmodule
`default_nettype wire

/* rtl/strongly_connected_components.sv */
// Top level: Tarjan strongly connected components search over a loaded graph.
//
//  channel   | ports                                             | handshake
//  ----------+---------------------------------------------------+---------------------------
//  command   | cmd, from_vertex, to_vertex                       | start high while busy low
//  result    | member_vertex, component_number, component_end,   | result_strobe, one cycle
//            | run_end                                           |
//  config    | cfg_wdata (vertex_count)                          | cfg_we
//
// Clear and ignored commands are decoded and return to idle; an edge add does a
// read-modify-write of one adjacency row. A find walks the graph depth-first, each
// step going through the adjacency, low-link and frame memories, which have one
// write port and one registered read port each.
// Asynchronous active-low reset empties the graph and sets vertex_count to 64.
// The receiver cannot stall; each result is flagged by result_strobe for exactly one cycle.
`default_nettype none
module strongly_connected_components
	import scc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [1:0]    cmd,
	input  wire logic [VW-1:0] from_vertex,
	input  wire logic [VW-1:0] to_vertex,
	input  wire logic          cfg_we,
	input  wire logic [CW-1:0] cfg_wdata,
	output logic               result_strobe,
	output logic [VW-1:0]      member_vertex,
	output logic [VW-1:0]      component_number,
	output logic               component_end,
	output logic               run_end
);
	dp_op_t     op;
	dp_status_t st;

	scc_ctrl u_ctrl (
		.clk, .arst_n, .start, .busy, .st, .op
	);

	scc_dp u_dp (
		.clk, .arst_n, .op, .st, .cmd, .from_vertex, .to_vertex,
		.cfg_we, .cfg_wdata, .result_strobe, .member_vertex,
		.component_number, .component_end, .run_end
	);
endmodule
`default_nettype wire
